// ===== hdl/swma_pkg.sv =====
// Shared widths and constants for the sliding window maximum average block.
package swma_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int SUM_W      = 38;
    localparam int AVG_W      = 48;
    localparam int LEN_W      = 7;
    localparam int WINDOW_MAX = 64;
    localparam int PTR_W      = $clog2(WINDOW_MAX);
    localparam int FRAC_W     = 16;
    localparam int DIVIDEND_W = SUM_W + FRAC_W;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);
    localparam int OUT_RAW_W  = SUM_W + AVG_W;
    localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(4);

endpackage

// ===== hdl/sliding_window_max_average.sv =====
// Sliding window maximum average: top level with sample ring, sequencer and result register.
//
// Usage. Samples arrive as beats on the slave stream: s_tdata carries one signed 32-bit
// sample and s_tlast marks the final sample of a sequence. The block keeps the newest
// window_len samples in a 64-entry ring, a running window sum and the largest full-window
// sum seen. On the last sample it sends one result beat on the master stream: the largest
// window sum, and that sum times 2^16 divided by window_len, truncated toward zero. If the
// sequence was shorter than the window, m_tuser is high and the data is all zeros.
// Each sample passes in turn through accept, ring read and difference, sum update with
// ring write and maximum compare; s_tready stays low until it is through, so a new
// sample is only taken once the last one is done. A last sample then goes through a
// check, the divider (54 one-bit steps and its done flag; skipped for a short sequence)
// and the output load, after which m_tvalid rises and s_tready returns in the same cycle.
// The result waits in an output register; while it waits, further samples are accepted,
// and only a following last sample holds until the receiver has taken the earlier result.
// Configuration: cfg_we writes window_len from cfg_wdata while the block is idle; 0 acts
// as 1, values above 64 act as 64, and every write drops the sequence in progress.
// Reset sets window_len to 4, clears the sequence and the output valid flag; the ring
// needs no clearing, as an entry is only read after it was written in the same sequence.
module sliding_window_max_average
(
    input  logic                               clk,
    input  logic                               rst_n,
    // Slave stream. s_tdata: [31:0] sample.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [swma_pkg::SAMPLE_W-1:0]      s_tdata,
    input  logic                               s_tlast,
    // Master stream. m_tdata: [37:0] max_window_sum, [85:38] max_average, [87:86] zero.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [swma_pkg::OUT_DATA_W-1:0]    m_tdata,
    // m_tuser: [0] too_short.
    output logic                               m_tuser,
    // Configuration: window_len.
    input  logic                               cfg_we,
    input  logic [swma_pkg::LEN_W-1:0]         cfg_wdata
);

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_DIFF,
        ST_SUM,
        ST_BEST,
        ST_CHECK,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t                                 state_reg, state_next;
    logic [swma_pkg::LEN_W-1:0]             len_reg, len_next;
    logic [swma_pkg::PTR_W-1:0]             wpos_reg, wpos_next;
    logic [swma_pkg::LEN_W-1:0]             fill_reg, fill_next;
    logic signed [swma_pkg::SUM_W-1:0]      sum_reg, sum_next;
    logic signed [swma_pkg::SUM_W-1:0]      best_reg, best_next;
    logic signed [swma_pkg::SAMPLE_W:0]     delta_reg, delta_next;
    logic [swma_pkg::SAMPLE_W-1:0]          smp_reg, smp_next;
    logic                                   last_reg, last_next;
    logic                                   full_reg, full_next;
    logic                                   filled_reg, filled_next;
    logic                                   short_reg, short_next;
    logic                                   oval_reg, oval_next;
    logic [swma_pkg::OUT_DATA_W-1:0]        odata_reg, odata_next;
    logic                                   ouser_reg, ouser_next;

    // Sample ring.
    logic [swma_pkg::SAMPLE_W-1:0]          ring_mem [swma_pkg::WINDOW_MAX];
    logic [swma_pkg::SAMPLE_W-1:0]          ring_rd_reg;
    logic                                   ring_we;

    logic                                   div_start;
    logic                                   div_done;
    logic signed [swma_pkg::AVG_W-1:0]      div_quot;
    logic [swma_pkg::LEN_W:0]               wpos_inc;
    logic [swma_pkg::LEN_W-1:0]             cfg_len;

    swma_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .value    (best_reg),
        .divisor  (len_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Out-of-range lengths are clamped once, at the write.
    always_comb
    begin
        if (cfg_wdata == '0)
        begin
            cfg_len = swma_pkg::LEN_W'(1);
        end
        else if (cfg_wdata > swma_pkg::LEN_W'(swma_pkg::WINDOW_MAX))
        begin
            cfg_len = swma_pkg::LEN_W'(swma_pkg::WINDOW_MAX);
        end
        else
        begin
            cfg_len = cfg_wdata;
        end
    end

    assign wpos_inc = {2'b00, wpos_reg} + 1'b1;

    always_comb
    begin
        state_next  = state_reg;
        len_next    = len_reg;
        wpos_next   = wpos_reg;
        fill_next   = fill_reg;
        sum_next    = sum_reg;
        best_next   = best_reg;
        delta_next  = delta_reg;
        smp_next    = smp_reg;
        last_next   = last_reg;
        full_next   = full_reg;
        filled_next = filled_reg;
        short_next  = short_reg;
        oval_next   = oval_reg;
        odata_next  = odata_reg;
        ouser_next  = ouser_reg;
        ring_we     = 1'b0;
        div_start   = 1'b0;

        if (oval_reg && m_tready)
        begin
            oval_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cfg_we)
                begin
                    len_next  = cfg_len;
                    wpos_next = '0;
                    fill_next = '0;
                    sum_next  = '0;
                    best_next = '0;
                end
                else if (s_tvalid)
                begin
                    smp_next   = s_tdata;
                    last_next  = s_tlast;
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF:
            begin
                // The ring read for the current slot has landed in ring_rd_reg.
                full_next   = (fill_reg >= len_reg);
                filled_next = (fill_reg < len_reg) && (fill_reg + 1'b1 == len_reg);
                if (fill_reg < len_reg)
                begin
                    delta_next = {smp_reg[swma_pkg::SAMPLE_W-1], smp_reg};
                end
                else
                begin
                    delta_next = {smp_reg[swma_pkg::SAMPLE_W-1], smp_reg}
                               - {ring_rd_reg[swma_pkg::SAMPLE_W-1], ring_rd_reg};
                end
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                ring_we  = 1'b1;
                sum_next = sum_reg + swma_pkg::SUM_W'(delta_reg);
                if (!full_reg)
                begin
                    fill_next = fill_reg + 1'b1;
                end
                wpos_next  = (wpos_inc >= {1'b0, len_reg}) ? '0
                                                           : wpos_inc[swma_pkg::PTR_W-1:0];
                state_next = ST_BEST;
            end
            ST_BEST:
            begin
                if (filled_reg || (full_reg && (sum_reg > best_reg)))
                begin
                    best_next = sum_reg;
                end
                state_next = last_reg ? ST_CHECK : ST_IDLE;
            end
            ST_CHECK:
            begin
                if (fill_reg < len_reg)
                begin
                    short_next = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    short_next = 1'b0;
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // Load only once any earlier result has been taken.
                if (!oval_reg || m_tready)
                begin
                    oval_next  = 1'b1;
                    ouser_next = short_reg;
                    if (short_reg)
                    begin
                        odata_next = '0;
                    end
                    else
                    begin
                        odata_next = swma_pkg::OUT_DATA_W'({div_quot, best_reg});
                    end
                    wpos_next  = '0;
                    fill_next  = '0;
                    sum_next   = '0;
                    best_next  = '0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            len_reg    <= swma_pkg::LEN_RESET;
            wpos_reg   <= '0;
            fill_reg   <= '0;
            sum_reg    <= '0;
            best_reg   <= '0;
            last_reg   <= 1'b0;
            full_reg   <= 1'b0;
            filled_reg <= 1'b0;
            short_reg  <= 1'b0;
            oval_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            len_reg    <= len_next;
            wpos_reg   <= wpos_next;
            fill_reg   <= fill_next;
            sum_reg    <= sum_next;
            best_reg   <= best_next;
            last_reg   <= last_next;
            full_reg   <= full_next;
            filled_reg <= filled_next;
            short_reg  <= short_next;
            oval_reg   <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        delta_reg <= delta_next;
        smp_reg   <= smp_next;
        odata_reg <= odata_next;
        ouser_reg <= ouser_next;
    end

    // The ring is read at the current slot every cycle and written in the sum update.
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[wpos_reg] <= smp_reg;
        end
        ring_rd_reg <= ring_mem[wpos_reg];
    end

    assign s_tready = (state_reg == ST_IDLE) && !cfg_we;
    assign m_tvalid = oval_reg;
    assign m_tdata  = odata_reg;
    assign m_tuser  = ouser_reg;

    // The fill count never passes the window length.
    assert property (@(posedge clk) disable iff (!rst_n) fill_reg <= len_reg)
        else $error("fill count exceeds window length");

    // The ring position stays inside the active window.
    assert property (@(posedge clk) disable iff (!rst_n) {1'b0, wpos_reg} < len_reg)
        else $error("ring position outside window");

    // A short sequence reports all-zero data.
    assert property (@(posedge clk) disable iff (!rst_n) (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("short sequence result carries data");

    // The divider only finishes while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n) div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside division state");

endmodule

// ===== hdl/swma_div.sv =====
// Bit-serial restoring divider: signed sum scaled by 2^16, divided by the window length.
module swma_div
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [swma_pkg::SUM_W-1:0]   value,
    input  logic        [swma_pkg::LEN_W-1:0]   divisor,
    output logic                                done,
    output logic signed [swma_pkg::AVG_W-1:0]   quotient
);

    logic                                 busy_reg, busy_next;
    logic                                 done_reg, done_next;
    logic                                 neg_reg, neg_next;
    logic [swma_pkg::DIV_CNT_W-1:0]       cnt_reg, cnt_next;
    logic [swma_pkg::LEN_W-1:0]           rem_reg, rem_next;
    logic [swma_pkg::LEN_W-1:0]           dvs_reg, dvs_next;
    logic [swma_pkg::DIVIDEND_W-1:0]      quo_reg, quo_next;
    logic [swma_pkg::SUM_W-1:0]           magnitude;
    logic [swma_pkg::LEN_W:0]             partial;
    logic [swma_pkg::LEN_W:0]             trial;

    // The remainder stays below the divisor, so one extra bit covers the shifted value.
    assign magnitude = value[swma_pkg::SUM_W-1] ? swma_pkg::SUM_W'(-value)
                                                : swma_pkg::SUM_W'(value);
    assign partial   = {rem_reg, quo_reg[swma_pkg::DIVIDEND_W-1]};
    assign trial     = partial - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            neg_next  = value[swma_pkg::SUM_W-1];
            cnt_next  = '0;
            rem_next  = '0;
            dvs_next  = divisor;
            quo_next  = {magnitude, {swma_pkg::FRAC_W{1'b0}}};
        end
        else if (busy_reg)
        begin
            if (!trial[swma_pkg::LEN_W])
            begin
                rem_next = trial[swma_pkg::LEN_W-1:0];
                quo_next = {quo_reg[swma_pkg::DIVIDEND_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = partial[swma_pkg::LEN_W-1:0];
                quo_next = {quo_reg[swma_pkg::DIVIDEND_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == swma_pkg::DIV_CNT_W'(swma_pkg::DIVIDEND_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            neg_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            neg_reg  <= neg_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    // The magnitude of the quotient never exceeds 2^47, so the low bits carry it whole.
    assign done     = done_reg;
    assign quotient = neg_reg ? swma_pkg::AVG_W'(-quo_reg[swma_pkg::AVG_W-1:0])
                              : swma_pkg::AVG_W'(quo_reg[swma_pkg::AVG_W-1:0]);

endmodule

// ===== tb/sliding_window_max_average_test.sv =====
// Self-checking testbench for the sliding window maximum average block.
`timescale 1ns / 1ps

module sliding_window_max_average_test;

    // One result beat and a round allowance for the divider plus the
    // sample path, used whenever the block must be left alone.
    localparam int unsigned SETTLE_CYCLES = 100;
    localparam int unsigned CYCLE_LIMIT   = 600000;
    localparam int unsigned RANDOM_ITEMS  = 850;
    localparam int unsigned RANDOM_RESULTS = 40;
    localparam int unsigned LONG_HOLD     = 400;
    localparam int unsigned SHOWN_FAILURES = 10;
    localparam int unsigned PAD_W         = swma_pkg::OUT_DATA_W - swma_pkg::SUM_W
                                          - swma_pkg::AVG_W;

    typedef struct packed {
        logic [swma_pkg::SUM_W-1:0] window_sum;
        logic [swma_pkg::AVG_W-1:0] average;
        logic                       too_short;
    } window_result_t;

    logic                              clk;
    logic                              rst_n;
    logic                              s_tvalid;
    logic                              s_tready;
    logic [swma_pkg::SAMPLE_W-1:0]     s_tdata;     // [31:0] sample
    logic                              s_tlast;
    logic                              m_tvalid;
    logic                              m_tready;
    // [37:0] max_window_sum, [85:38] max_average, [87:86] zero
    logic [swma_pkg::OUT_DATA_W-1:0]   m_tdata;
    logic                              m_tuser;     // [0] too_short
    logic                              cfg_we;
    logic [swma_pkg::LEN_W-1:0]        cfg_wdata;

    // Shared between the stimulus, the receiver and the checker.
    window_result_t          pending_results[$];
    int unsigned             results_predicted;
    int unsigned             error_count;
    int unsigned             hold_request;
    bit                      rx_steady;
    int unsigned             cycle_count;

    // Our own copy of the block's sequence state.
    logic [swma_pkg::LEN_W-1:0]        len_setting;
    logic [swma_pkg::SAMPLE_W-1:0]     ring_copy [swma_pkg::WINDOW_MAX];
    int unsigned             ring_slot;
    int unsigned             ring_fill;
    longint                  window_total;
    longint                  best_total;

    sliding_window_max_average dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // A length of zero behaves as one; anything above the ring size is
    // clamped to the ring size.
    function automatic int unsigned active_span();
        if (len_setting == '0)
            return 1;
        if (len_setting > swma_pkg::WINDOW_MAX)
            return swma_pkg::WINDOW_MAX;
        return 32'(len_setting);
    endfunction

    function automatic void clear_window_state();
        ring_slot    = 0;
        ring_fill    = 0;
        window_total = 0;
        best_total   = 0;
    endfunction

    // Advances the window by one accepted sample and, on the last sample
    // of a sequence, queues the result the block should produce.
    function automatic void advance_window(logic [swma_pkg::SAMPLE_W-1:0] raw, logic is_last);
        int unsigned    span;
        longint         value;
        longint         quotient;
        window_result_t res;
        span  = active_span();
        value = longint'(signed'(raw));
        if (ring_fill < span)
        begin
            window_total += value;
            ring_copy[ring_slot] = raw;
            ring_fill++;
            if (ring_fill == span)
                best_total = window_total;
        end
        else
        begin
            window_total += value - longint'(signed'(ring_copy[ring_slot]));
            ring_copy[ring_slot] = raw;
            if (window_total > best_total)
                best_total = window_total;
        end
        ring_slot = (ring_slot + 1 >= span) ? 0 : ring_slot + 1;
        if (is_last)
        begin
            if (ring_fill < span)
            begin
                res.window_sum = '0;
                res.average    = '0;
                res.too_short  = 1'b1;
            end
            else
            begin
                // Signed division truncates toward zero, as the block must.
                quotient       = (best_total * 64'sd65536) / longint'(span);
                res.window_sum = best_total[swma_pkg::SUM_W-1:0];
                res.average    = quotient[swma_pkg::AVG_W-1:0];
                res.too_short  = 1'b0;
            end
            pending_results = {pending_results, res};
            results_predicted++;
            clear_window_state();
        end
    endfunction

    // ------------------------------------------------------------------
    // Random choices
    // ------------------------------------------------------------------

    // Mostly no gap, sometimes a few cycles, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [swma_pkg::SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom();
            4, 5, 6:    return swma_pkg::SAMPLE_W'($urandom_range(0, 2000) - 1000);
            7:          return 32'h7FFF_FFFF;
            8:          return 32'h8000_0000;
            default:    return $urandom() | 32'h8000_0000;
        endcase
    endfunction

    // Short windows dominate so that results come often; the full ring and
    // the out-of-range settings still turn up regularly.
    function automatic logic [swma_pkg::LEN_W-1:0] pick_window_len();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return swma_pkg::LEN_W'($urandom_range(1, 8));
        if (roll < 70)
            return swma_pkg::LEN_W'($urandom_range(9, 32));
        if (roll < 78)
            return swma_pkg::LEN_W'($urandom_range(33, 63));
        if (roll < 88)
            return swma_pkg::LEN_W'(swma_pkg::WINDOW_MAX);
        if (roll < 93)
            return '0;
        return swma_pkg::LEN_W'($urandom_range(65, 127));
    endfunction

    function automatic void note_failure(string msg);
        if (error_count < SHOWN_FAILURES)
            $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endfunction

    // ------------------------------------------------------------------
    // Shared stimulus tasks. Every task starts and ends on a falling edge.
    // ------------------------------------------------------------------

    // Offers one sample beat and returns once it has been accepted. Valid is
    // left high so that a following beat can go out back to back.
    task automatic send_sample(logic [swma_pkg::SAMPLE_W-1:0] value, logic is_last,
                               int unsigned gap);
        if (gap != 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  = value;
        s_tlast  = is_last;
        s_tvalid = 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        advance_window(value, is_last);
        @(negedge clk);
    endtask

    task automatic send_sequence(logic [swma_pkg::SAMPLE_W-1:0] values[$]);
        foreach (values[i])
            send_sample(values[i], i == values.size() - 1, pick_gap());
    endtask

    // Stops offering beats and waits until every queued result has been
    // seen, then leaves the block time to finish any sample still in flight.
    task automatic wait_results_drained();
        s_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // Only called with the block idle, i.e. after wait_results_drained.
    task automatic write_window_len(logic [swma_pkg::LEN_W-1:0] value);
        cfg_wdata = value;
        cfg_we    = 1'b1;
        @(negedge clk);
        cfg_we    = 1'b0;
        len_setting = value;
        clear_window_state();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // The reset length of four, with the largest and smallest samples: the
    // first window holds the maximum and the sliding step loses against it.
    task automatic test_default_length();
        send_sequence('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        32'h8000_0000});
    endtask

    // Sequences ending before the first window is full must raise the flag
    // and zero the data.
    task automatic test_short_sequences();
        send_sequence('{32'h1234_5678});
        send_sequence('{32'hFFFF_FFFF, 32'h0000_0000});
    endtask

    task automatic test_length_limits();
        // Zero behaves as a window of one; a negative maximum stays negative.
        wait_results_drained();
        write_window_len('0);
        send_sequence('{32'h8000_0000, 32'h8000_0000});
        // A negative sum that does not divide evenly shows truncation toward zero.
        wait_results_drained();
        write_window_len(swma_pkg::LEN_W'(3));
        send_sequence('{32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF});
        // Above the ring size the window is the whole ring, so three samples are short.
        wait_results_drained();
        write_window_len(swma_pkg::LEN_W'(127));
        send_sequence('{32'h0000_0001, 32'h0000_0002, 32'h0000_0003});
        wait_results_drained();
        write_window_len(swma_pkg::LEN_W'(swma_pkg::WINDOW_MAX));
        send_sequence('{32'h7FFF_FFFF});
        wait_results_drained();
        write_window_len(swma_pkg::LEN_W'(1));
        send_sequence('{32'h7FFF_FFFF});
    endtask

    // A write part way through a sequence drops the samples taken so far.
    task automatic test_write_mid_sequence();
        wait_results_drained();
        write_window_len(swma_pkg::LEN_W'(2));
        send_sample(32'h0000_0100, 1'b0, 0);
        send_sample(32'h0000_0200, 1'b0, 0);
        send_sample(32'h0000_0300, 1'b0, 0);
        wait_results_drained();
        write_window_len(swma_pkg::LEN_W'(2));
        send_sequence('{32'h0000_0400});
        send_sequence('{32'h0000_0005, 32'hFFFF_FFF0});
    endtask

    // The receiver refuses results for a long stretch while the sender keeps
    // offering complete sequences, so the output register fills, the next
    // result waits in the sequencer and further beats are held at the input.
    task automatic test_output_backpressure();
        wait_results_drained();
        write_window_len(swma_pkg::LEN_W'(3));
        hold_request = LONG_HOLD;
        repeat (4)
        begin
            for (int i = 0; i < 4; i++)
                send_sample(pick_sample(), i == 3, 0);
        end
        // The sender now pauses until everything outstanding has come back.
        wait_results_drained();
    endtask

    // Phases of random window settings, each carrying a handful of
    // sequences: mostly well formed, some cut short, some bare noise.
    task automatic test_random_sequences();
        int unsigned items;
        int unsigned first_result;
        int unsigned span;
        int unsigned seq_len;
        int unsigned roll;
        bit          steady;
        items        = 0;
        first_result = results_predicted;
        while (items < RANDOM_ITEMS || results_predicted - first_result < RANDOM_RESULTS)
        begin
            wait_results_drained();
            write_window_len(pick_window_len());
            span = active_span();
            repeat ($urandom_range(2, 6))
            begin
                roll = $urandom_range(0, 99);
                if (roll < 70 || span == 1)
                    seq_len = span + $urandom_range(0, span + 4);
                else if (roll < 85)
                    seq_len = $urandom_range(1, span - 1);
                else
                    seq_len = $urandom_range(1, 3);
                steady    = ($urandom_range(0, 4) == 0);
                rx_steady = steady;
                for (int i = 0; i < seq_len; i++)
                begin
                    send_sample(pick_sample(), i == seq_len - 1, steady ? 0 : pick_gap());
                    items++;
                end
            end
            rx_steady = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, steady stretches, and long hold-offs on
    // request, each counted here in cycles.
    // ------------------------------------------------------------------
    initial
    begin : result_receiver
        int unsigned stall_left;
        int unsigned hold_len;
        stall_left = 0;
        m_tready   = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request != 0)
            begin
                hold_len     = hold_request;
                hold_request = 0;
                m_tready     = 1'b0;
                repeat (hold_len) @(negedge clk);
            end
            if (stall_left == 0 && !rx_steady && $urandom_range(0, 3) == 0)
                stall_left = pick_gap();
            if (stall_left != 0)
            begin
                m_tready = 1'b0;
                stall_left--;
            end
            else
                m_tready = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Checker: every accepted result beat against the oldest expectation.
    // ------------------------------------------------------------------
    initial
    begin : result_checker
        window_result_t              want;
        logic [swma_pkg::SUM_W-1:0]  got_sum;
        logic [swma_pkg::AVG_W-1:0]  got_avg;
        logic [PAD_W-1:0]            got_pad;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                got_sum = m_tdata[swma_pkg::SUM_W-1:0];
                got_avg = m_tdata[swma_pkg::SUM_W +: swma_pkg::AVG_W];
                got_pad = m_tdata[swma_pkg::OUT_DATA_W-1 -: PAD_W];
                if (pending_results.size() == 0)
                    note_failure($sformatf("unexpected result beat: sum %h average %h short %b",
                                           got_sum, got_avg, m_tuser));
                else
                begin
                    want = pending_results.pop_front();
                    if (got_sum !== want.window_sum)
                        note_failure($sformatf("max_window_sum expected %h got %h",
                                               want.window_sum, got_sum));
                    if (got_avg !== want.average)
                        note_failure($sformatf("max_average expected %h got %h",
                                               want.average, got_avg));
                    if (m_tuser !== want.too_short)
                        note_failure($sformatf("too_short expected %b got %b",
                                               want.too_short, m_tuser));
                    if (got_pad !== '0)
                        note_failure($sformatf("padding bits expected 0 got %b", got_pad));
                end
            end
        end
    end

    // A hung handshake ends the run here.
    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : main_sequence
        rst_n             = 1'b0;
        s_tvalid          = 1'b0;
        s_tdata           = '0;
        s_tlast           = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = '0;
        hold_request      = 0;
        rx_steady         = 1'b0;
        error_count       = 0;
        results_predicted = 0;
        len_setting       = swma_pkg::LEN_RESET;
        clear_window_state();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_default_length();
        test_short_sequences();
        test_length_limits();
        test_write_mid_sequence();
        test_output_backpressure();
        test_random_sequences();

        s_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
